>>> sv/lbfm_pkg.sv
// Shared types and constants for the four-momentum Lorentz boost pipeline.
// No dependencies; every other file imports this package.
package lbfm_pkg;

	localparam int E_W     = 47;           // unsigned energy / mass width
	localparam int P_W     = 48;           // signed momentum width
	localparam int PROD_W  = 96;           // 48 x 48 magnitude product
	localparam int NUM_W   = 98;           // signed sum of four products
	localparam int Q_STEPS = 49;           // quotient bits per division
	localparam int Q_W     = Q_STEPS + 1;  // rounded quotient width
	localparam int HALF_W  = 24;           // partial product operand width
	localparam int N_AX    = 3;            // momentum components

	localparam logic [E_W-1:0] E_MAX = {E_W{1'b1}};
	localparam logic [P_W-1:0] P_MAX = {1'b0, {(P_W-1){1'b1}}};
	localparam logic [P_W-1:0] P_MIN = {1'b1, {(P_W-1){1'b0}}};

	// Divider result handed back to the top level.
	typedef struct packed {
		logic           vld;
		logic           ovf;
		logic [Q_W-1:0] quot;
	} div_res_t;

	// Per-item data that rides alongside the arithmetic.
	typedef struct packed {
		logic                     bypass;
		logic                     inv;
		logic [E_W-1:0]           m1;
		logic [E_W-1:0]           e2;
		logic [P_W-1:0]           den;
		logic [N_AX-1:0]          p1neg;
		logic [N_AX-1:0]          prodneg;
		logic [N_AX-1:0][P_W-1:0] p1mag;
		logic [N_AX-1:0][P_W-1:0] p2;
	} side_t;

endpackage

>>> sv/lbfm_mul.sv
// Two-stage 48 x 48 unsigned multiplier built from four 24 x 24 partial products.
// Depends on lbfm_pkg.
module lbfm_mul
	import lbfm_pkg::*;
(
	input  logic              clk,
	input  logic [P_W-1:0]    a,
	input  logic [P_W-1:0]    b,
	output logic [PROD_W-1:0] prod
);

	logic [2*HALF_W-1:0] ll_s1, lh_s1, hl_s1, hh_s1;

	always_ff @(posedge clk) begin
		ll_s1 <= a[HALF_W-1:0] * b[HALF_W-1:0];
		lh_s1 <= a[HALF_W-1:0] * b[P_W-1:HALF_W];
		hl_s1 <= a[P_W-1:HALF_W] * b[HALF_W-1:0];
		hh_s1 <= a[P_W-1:HALF_W] * b[P_W-1:HALF_W];
	end

	always_ff @(posedge clk) begin
		prod <= (PROD_W'(hh_s1) << (2 * HALF_W))
			+ ((PROD_W'(lh_s1) + PROD_W'(hl_s1)) << HALF_W)
			+ PROD_W'(ll_s1);
	end

endmodule

>>> sv/lbfm_div.sv
// Pipelined restoring divider: 96-bit magnitude over 48-bit divisor, one quotient
// bit per stage, rounded to nearest with ties up. Depends on lbfm_pkg.
module lbfm_div
	import lbfm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	input  logic [PROD_W-1:0] dividend,
	input  logic [P_W-1:0]    divisor,
	output div_res_t          res
);

	localparam int HI_W = PROD_W - Q_STEPS;

	logic [P_W-1:0]     rem_s [0:Q_STEPS];
	logic [Q_STEPS-1:0] low_s [0:Q_STEPS];
	logic [Q_STEPS-1:0] q_s   [0:Q_STEPS];
	logic [P_W-1:0]     dv_s  [0:Q_STEPS];
	logic               ovf_s [0:Q_STEPS];
	logic               vld_s [0:Q_STEPS];
	logic [P_W:0]       rem2;
	logic               up;
	logic [Q_W-1:0]     quot_q;
	logic               ovf_q;
	logic               vld_q;

	// The quotient overflows Q_STEPS bits when the high part already reaches the divisor.
	always_ff @(posedge clk) begin
		rem_s[0] <= P_W'(dividend[PROD_W-1:Q_STEPS]);
		low_s[0] <= dividend[Q_STEPS-1:0];
		q_s[0]   <= '0;
		dv_s[0]  <= divisor;
		ovf_s[0] <= P_W'(dividend[PROD_W-1:Q_STEPS]) >= divisor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= in_vld;
		end
	end

	for (genvar k = 0; k < Q_STEPS; k++) begin : g_step
		logic [P_W:0] r2;
		logic [P_W:0] diff;
		logic         ge;

		assign r2   = {rem_s[k], low_s[k][Q_STEPS-1]};
		assign diff = r2 - {1'b0, dv_s[k]};
		assign ge   = r2 >= {1'b0, dv_s[k]};

		always_ff @(posedge clk) begin
			rem_s[k+1] <= ge ? diff[P_W-1:0] : r2[P_W-1:0];
			low_s[k+1] <= {low_s[k][Q_STEPS-2:0], 1'b0};
			q_s[k+1]   <= {q_s[k][Q_STEPS-2:0], ge};
			dv_s[k+1]  <= dv_s[k];
			ovf_s[k+1] <= ovf_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	assign rem2 = {rem_s[Q_STEPS], 1'b0};
	assign up   = rem2 >= {1'b0, dv_s[Q_STEPS]};

	always_ff @(posedge clk) begin
		quot_q <= {1'b0, q_s[Q_STEPS]} + Q_W'(up);
		ovf_q  <= ovf_s[Q_STEPS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_s[Q_STEPS];
		end
	end

	assign res.vld  = vld_q;
	assign res.ovf  = ovf_q;
	assign res.quot = quot_q;

endmodule

>>> sv/lorentz_boost_four_momentum.sv
// Lorentz boost of a child four-momentum into the lab frame, fully pipelined.
// An accepted request reaches its done strobe through two 51-stage dividers and
// two 2-stage multiplier banks in series; one request per cycle.
// busy is always low and the output cannot be stalled. Reset clears only the valid bits.
// Depends on lbfm_pkg, lbfm_mul and lbfm_div.
module lorentz_boost_four_momentum
	import lbfm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [E_W-1:0]        parent_mass,
	input  logic [E_W-1:0]        parent_energy,
	input  logic signed [P_W-1:0] parent_mom_x,
	input  logic signed [P_W-1:0] parent_mom_y,
	input  logic signed [P_W-1:0] parent_mom_z,
	input  logic [E_W-1:0]        child_energy,
	input  logic signed [P_W-1:0] child_mom_x,
	input  logic signed [P_W-1:0] child_mom_y,
	input  logic signed [P_W-1:0] child_mom_z,
	output logic                  done,
	output logic [E_W-1:0]        lab_energy,
	output logic signed [P_W-1:0] lab_mom_x,
	output logic signed [P_W-1:0] lab_mom_y,
	output logic signed [P_W-1:0] lab_mom_z,
	output logic                  invalid
);

	// Stage numbers along the pipe. Stage 1 holds the captured request.
	localparam int ST_NUM  = 7;    // numerator magnitude into the energy divider
	localparam int ST_D1   = 58;   // energy quotient out
	localparam int ST_E3   = 59;   // saturated lab energy
	localparam int ST_S    = 60;   // E2 + E3 into the momentum multipliers
	localparam int ST_P2   = 62;   // momentum products into the momentum dividers
	localparam int ST_D2   = 113;  // momentum quotients out
	localparam int ST_SUM  = 115;  // quotient plus child momentum
	localparam int ST_LAST = 116;  // output registers
	localparam int NEG_LEN = ST_D1 - ST_NUM;

	// The pipeline never stalls, so a request is taken in every cycle.
	assign busy = 1'b0;

	logic                     accept;
	logic [N_AX-1:0][P_W-1:0] p1_in, p2_in;
	side_t                    side_in;
	side_t                    side_s [1:ST_LAST];
	logic                     vld_s  [1:ST_LAST];

	assign accept = start && !busy;
	assign p1_in  = {parent_mom_z, parent_mom_y, parent_mom_x};
	assign p2_in  = {child_mom_z, child_mom_y, child_mom_x};

	// Magnitudes and signs for the sign-magnitude multipliers are formed at capture.
	logic [N_AX-1:0][P_W-1:0] p2mag_in;

	always_comb begin
		side_in.bypass = (parent_mass == '0) || (parent_energy == parent_mass);
		side_in.inv    = parent_mass == '0;
		side_in.m1     = parent_mass;
		side_in.e2     = child_energy;
		side_in.den    = P_W'(parent_energy) + P_W'(parent_mass);
		side_in.p2     = p2_in;
		for (int k = 0; k < N_AX; k++) begin
			side_in.p1neg[k]   = p1_in[k][P_W-1];
			side_in.prodneg[k] = p1_in[k][P_W-1] ^ p2_in[k][P_W-1];
			side_in.p1mag[k]   = p1_in[k][P_W-1] ? (~p1_in[k] + 1'b1) : p1_in[k];
			p2mag_in[k]        = p2_in[k][P_W-1] ? (~p2_in[k] + 1'b1) : p2_in[k];
		end
	end

	// Side data shift line: one register per stage, tapped where each field is needed.
	always_ff @(posedge clk) begin
		side_s[1] <= side_in;
		for (int i = 2; i <= ST_LAST; i++) begin
			side_s[i] <= side_s[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= ST_LAST; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else begin
			vld_s[1] <= accept;
			for (int i = 2; i <= ST_LAST; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Stage 1 operands for the first multiplier bank.
	logic [P_W-1:0]           e1_s1;
	logic [P_W-1:0]           e2_s1;
	logic [N_AX-1:0][P_W-1:0] p2mag_s1;

	always_ff @(posedge clk) begin
		e1_s1    <= P_W'(parent_energy);
		e2_s1    <= P_W'(child_energy);
		p2mag_s1 <= p2mag_in;
	end

	// Stages 2 and 3: E1*E2 and the three |p1|*|p2| products.
	logic [PROD_W-1:0] pe_s3;
	logic [PROD_W-1:0] pp_s3 [N_AX];

	lbfm_mul u_mul_e (
		.clk  (clk),
		.a    (e1_s1),
		.b    (e2_s1),
		.prod (pe_s3)
	);

	for (genvar k = 0; k < N_AX; k++) begin : g_mul1
		lbfm_mul u_mul_p (
			.clk  (clk),
			.a    (side_s[1].p1mag[k]),
			.b    (p2mag_s1[k]),
			.prod (pp_s3[k])
		);
	end

	// Stage 4 applies the product signs, stages 5 and 6 add them as a two-level tree.
	logic signed [NUM_W-1:0] pe_s4;
	logic signed [NUM_W-1:0] pp_s4 [N_AX];
	logic signed [NUM_W-1:0] sa_s5, sb_s5;
	logic signed [NUM_W-1:0] num_s6;

	always_ff @(posedge clk) begin
		pe_s4 <= $signed(NUM_W'(pe_s3));
		for (int k = 0; k < N_AX; k++) begin
			pp_s4[k] <= side_s[3].prodneg[k] ? -$signed(NUM_W'(pp_s3[k]))
				: $signed(NUM_W'(pp_s3[k]));
		end
		sa_s5  <= pe_s4 + pp_s4[0];
		sb_s5  <= pp_s4[1] + pp_s4[2];
		num_s6 <= sa_s5 + sb_s5;
	end

	// Stage 7: numerator magnitude and sign. The magnitude stays below 2^96.
	logic [NUM_W-1:0]  num_abs;
	logic [PROD_W-1:0] mag_s7;
	logic              neg_line [0:NEG_LEN];

	assign num_abs = num_s6[NUM_W-1] ? NUM_W'(-num_s6) : NUM_W'(num_s6);

	always_ff @(posedge clk) begin
		mag_s7      <= num_abs[PROD_W-1:0];
		neg_line[0] <= num_s6[NUM_W-1];
		for (int i = 1; i <= NEG_LEN; i++) begin
			neg_line[i] <= neg_line[i-1];
		end
	end

	// Energy divider: |E1*E2 + p1.p2| / M1.
	div_res_t d1_res;

	lbfm_div u_div_e (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s[ST_NUM]),
		.dividend (mag_s7),
		.divisor  (P_W'(side_s[ST_NUM].m1)),
		.res      (d1_res)
	);

	// Stage 59: a negative energy clamps to zero, a large one to full scale.
	// The clamped value is the one used in the momentum formula.
	logic [E_W-1:0] e3_s59;
	logic [P_W-1:0] s_s60;

	always_ff @(posedge clk) begin
		if (neg_line[NEG_LEN]) begin
			e3_s59 <= '0;
		end else if (d1_res.ovf || (d1_res.quot > Q_W'(E_MAX))) begin
			e3_s59 <= E_MAX;
		end else begin
			e3_s59 <= d1_res.quot[E_W-1:0];
		end
		s_s60 <= P_W'(side_s[ST_E3].e2) + P_W'(e3_s59);
	end

	// Stages 61 and 62: |p1| * (E2 + E3), then one divider per axis by E1 + M1.
	logic [PROD_W-1:0] pm_s62 [N_AX];
	div_res_t          d2_res [N_AX];

	for (genvar k = 0; k < N_AX; k++) begin : g_axis
		lbfm_mul u_mul_s (
			.clk  (clk),
			.a    (side_s[ST_S].p1mag[k]),
			.b    (s_s60),
			.prod (pm_s62[k])
		);

		lbfm_div u_div_p (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld_s[ST_P2]),
			.dividend (pm_s62[k]),
			.divisor  (side_s[ST_P2].den),
			.res      (d2_res[k])
		);
	end

	// Stage 114 restores the sign, stage 115 adds the child momentum, stage 116
	// saturates. An overflowed quotient already lies far outside the output range.
	logic signed [Q_W:0]   t_s114   [N_AX];
	logic                  ovf_s114 [N_AX];
	logic signed [Q_W+1:0] sum_s115 [N_AX];
	logic                  ovf_s115 [N_AX];
	logic [P_W-1:0]        sat_mom  [N_AX];

	always_ff @(posedge clk) begin
		for (int k = 0; k < N_AX; k++) begin
			t_s114[k]   <= side_s[ST_D2].p1neg[k] ? -$signed({1'b0, d2_res[k].quot})
				: $signed({1'b0, d2_res[k].quot});
			ovf_s114[k] <= d2_res[k].ovf;
			sum_s115[k] <= (Q_W+2)'(t_s114[k])
				+ (Q_W+2)'($signed(side_s[ST_SUM-1].p2[k]));
			ovf_s115[k] <= ovf_s114[k];
		end
	end

	always_comb begin
		for (int k = 0; k < N_AX; k++) begin
			if (ovf_s115[k]) begin
				sat_mom[k] = side_s[ST_SUM].p1neg[k] ? P_MIN : P_MAX;
			end else if (sum_s115[k][Q_W+1:P_W-1] == '0
				|| sum_s115[k][Q_W+1:P_W-1] == '1) begin
				sat_mom[k] = sum_s115[k][P_W-1:0];
			end else begin
				sat_mom[k] = sum_s115[k][Q_W+1] ? P_MIN : P_MAX;
			end
		end
	end

	// A zero-mass parent or a parent at rest passes the child through unchanged.
	logic [E_W-1:0] e3_line [ST_E3+1:ST_SUM];

	always_ff @(posedge clk) begin
		e3_line[ST_E3+1] <= e3_s59;
		for (int i = ST_E3 + 2; i <= ST_SUM; i++) begin
			e3_line[i] <= e3_line[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (side_s[ST_SUM].bypass) begin
			lab_energy <= side_s[ST_SUM].e2;
			lab_mom_x  <= side_s[ST_SUM].p2[0];
			lab_mom_y  <= side_s[ST_SUM].p2[1];
			lab_mom_z  <= side_s[ST_SUM].p2[2];
		end else begin
			lab_energy <= e3_line[ST_SUM];
			lab_mom_x  <= sat_mom[0];
			lab_mom_y  <= sat_mom[1];
			lab_mom_z  <= sat_mom[2];
		end
		invalid <= side_s[ST_SUM].inv;
	end

	assign done = vld_s[ST_LAST];

	// The energy divider must stay aligned with the side data line.
	a_div_e_align: assert property (@(posedge clk) disable iff (!arst_n)
		d1_res.vld == vld_s[ST_D1])
		else $error("energy divider out of step with side data");

	// The momentum dividers must stay aligned with the side data line.
	a_div_p_align: assert property (@(posedge clk) disable iff (!arst_n)
		(d2_res[0].vld == vld_s[ST_D2]) && (d2_res[1].vld == vld_s[ST_D2])
		&& (d2_res[2].vld == vld_s[ST_D2]))
		else $error("momentum dividers out of step with side data");

	// An invalid parent returns the child energy it came with.
	a_inv_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid |-> lab_energy == side_s[ST_LAST].e2)
		else $error("invalid result does not pass the child through");

	// The invalid flag is only raised on the pass-through path.
	a_inv_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(invalid && !side_s[ST_LAST].bypass))
		else $error("invalid flag outside the pass-through path");

endmodule

>>> dv/tb.sv
// Self-checking testbench for lorentz_boost_four_momentum: directed and random requests,
// each result predicted with wide exact integer arithmetic and compared field by field.
// Depends on lbfm_pkg and the RTL of the boost pipeline.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lbfm_pkg::*;

	// One lab-frame four-momentum as the block should report it.
	typedef struct {
		logic [E_W-1:0] energy;
		logic [P_W-1:0] mx, my, mz;
		logic           inv;
	} boosted_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [E_W-1:0] parent_mass = '0, parent_energy = '0, child_energy = '0;
	logic signed [P_W-1:0] parent_mom_x = '0, parent_mom_y = '0, parent_mom_z = '0;
	logic signed [P_W-1:0] child_mom_x = '0, child_mom_y = '0, child_mom_z = '0;
	logic done;
	logic [E_W-1:0] lab_energy;
	logic signed [P_W-1:0] lab_mom_x, lab_mom_y, lab_mom_z;
	logic invalid;

	boosted_t expected_boosts[$];
	int errors = 0;
	int sent = 0;
	int checked = 0;
	int invalid_seen = 0;

	always #5 clk = ~clk;

	lorentz_boost_four_momentum dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.parent_mass(parent_mass), .parent_energy(parent_energy),
		.parent_mom_x(parent_mom_x), .parent_mom_y(parent_mom_y),
		.parent_mom_z(parent_mom_z), .child_energy(child_energy),
		.child_mom_x(child_mom_x), .child_mom_y(child_mom_y),
		.child_mom_z(child_mom_z), .done(done), .lab_energy(lab_energy),
		.lab_mom_x(lab_mom_x), .lab_mom_y(lab_mom_y), .lab_mom_z(lab_mom_z),
		.invalid(invalid)
	);

	// Signed division rounded to nearest, ties away from zero. The divisor is positive.
	function automatic logic signed [159:0] div_round(logic signed [159:0] n,
			logic signed [159:0] d);
		logic signed [159:0] mag, q, r;
		mag = n < 0 ? -n : n;
		q = mag / d;
		r = mag - q * d;
		if (d - r <= r)
			q = q + 1;
		return n < 0 ? -q : q;
	endfunction

	function automatic logic [P_W-1:0] clamp_mom(logic signed [159:0] v);
		if (v > 160'sd140737488355327)
			return P_MAX;
		if (v < -160'sd140737488355328)
			return P_MIN;
		return v[P_W-1:0];
	endfunction

	// Lab-frame boost of the child: E3 = (E1*E2 + p1.p2)/M1, p3 = p2 + p1*(E2+E3)/(E1+M1).
	function automatic boosted_t boost_child(logic [E_W-1:0] m1, logic [E_W-1:0] e1,
			logic signed [P_W-1:0] p1 [3], logic [E_W-1:0] e2,
			logic signed [P_W-1:0] p2 [3]);
		boosted_t b;
		logic signed [159:0] num, e3w, s, den, t;
		logic signed [P_W-1:0] mom [3];
		if (m1 == 0 || e1 == m1) begin
			b.energy = e2;
			b.mx = p2[0];
			b.my = p2[1];
			b.mz = p2[2];
			b.inv = (m1 == 0);
			return b;
		end
		num = $signed({113'd0, e1}) * $signed({113'd0, e2});
		for (int k = 0; k < 3; k++)
			num = num + 160'(p1[k]) * 160'(p2[k]);
		e3w = div_round(num, $signed({113'd0, m1}));
		if (e3w < 0)
			b.energy = '0;
		else if (e3w > 160'sd140737488355327)
			b.energy = E_MAX;
		else
			b.energy = e3w[E_W-1:0];
		// The clamped energy feeds the momentum formula.
		s = $signed({113'd0, e2}) + $signed({113'd0, b.energy});
		den = $signed({113'd0, e1}) + $signed({113'd0, m1});
		for (int k = 0; k < 3; k++) begin
			t = div_round(160'(p1[k]) * s, den);
			mom[k] = clamp_mom(t + 160'(p2[k]));
		end
		b.mx = mom[0];
		b.my = mom[1];
		b.mz = mom[2];
		b.inv = 1'b0;
		return b;
	endfunction

	// Random 47-bit or 48-bit value; kind picks full range, small magnitude or an extreme.
	function automatic logic [P_W-1:0] rand_field(int kind);
		logic [P_W-1:0] v;
		v = {$urandom, $urandom};
		case (kind)
			0: v = v;
			1: v = {{24{v[47]}}, v[23:0]};
			2: v = v[47] ? P_MIN : P_MAX;
			default: v = {{14{v[47]}}, v[33:0]};
		endcase
		return v;
	endfunction

	// With with_gaps set, waits a random gap, mostly short and sometimes long; then sends one request.
	task automatic send_boost(logic [E_W-1:0] m1, logic [E_W-1:0] e1,
			logic [P_W-1:0] px, logic [P_W-1:0] py, logic [P_W-1:0] pz,
			logic [E_W-1:0] e2, logic [P_W-1:0] cx, logic [P_W-1:0] cy,
			logic [P_W-1:0] cz, bit with_gaps);
		int gap;
		logic signed [P_W-1:0] p1 [3];
		logic signed [P_W-1:0] p2 [3];
		gap = 0;
		if (with_gaps)
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		parent_mass <= m1;
		parent_energy <= e1;
		parent_mom_x <= px;
		parent_mom_y <= py;
		parent_mom_z <= pz;
		child_energy <= e2;
		child_mom_x <= cx;
		child_mom_y <= cy;
		child_mom_z <= cz;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		p1[0] = px; p1[1] = py; p1[2] = pz;
		p2[0] = cx; p2[1] = cy; p2[2] = cz;
		expected_boosts.push_back(boost_child(m1, e1, p1, e2, p2));
		sent++;
	endtask

	task automatic idle_line();
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Pauses the sender until every outstanding result has come back.
	task automatic drain_pipeline();
		idle_line();
		while (expected_boosts.size() != 0)
			@(posedge clk);
	endtask

	// Field extremes, a zero-mass parent, a parent at rest and a realistic boost.
	task automatic test_directed();
		logic [E_W-1:0] one;
		one = 47'd1 << 24;
		send_boost('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
		send_boost('0, E_MAX, P_MAX, P_MIN, P_MAX, E_MAX, P_MIN, P_MAX, P_MIN, 1'b0);
		send_boost(one, one, '0, '0, '0, one * 2, one, P_MIN, P_MAX, 1'b0);
		send_boost(E_MAX, E_MAX, P_MAX, P_MAX, P_MAX, E_MAX, P_MAX, P_MAX, P_MAX, 1'b0);
		send_boost(E_MAX, E_MAX - 1, P_MAX, P_MAX, P_MAX, E_MAX, P_MAX, P_MAX, P_MAX,
			1'b0);
		send_boost(47'd1, E_MAX, P_MIN, P_MIN, P_MIN, E_MAX, P_MAX, P_MAX, P_MAX, 1'b0);
		send_boost(47'd1, E_MAX, P_MAX, P_MAX, P_MAX, E_MAX, P_MAX, P_MAX, P_MAX, 1'b0);
		send_boost(47'd1, 47'd2, '0, '0, '0, 47'd1, 48'd1, -48'sd1, '0, 1'b0);
		// Parent of mass 3 moving with momentum 4 along z, energy 5.
		send_boost(one * 3, one * 5, '0, '0, 48'(one) * 4, one, '0, '0, '0, 1'b0);
		send_boost(one * 3, one * 5, 48'(one) * 4, '0, '0, one, -48'(one) / 2, '0, '0,
			1'b0);
		send_boost(one * 3, one * 5, '0, -48'(one) * 4, '0, one * 2, '0, 48'(one), '0,
			1'b0);
		// Negative energy numerator, clamped to zero.
		send_boost(one, one * 2, P_MAX, '0, '0, one, P_MIN, '0, '0, 1'b0);
		send_boost(47'd3, 47'd5, 48'd1, '0, '0, 47'd1, '0, '0, '0, 1'b0);
		send_boost(47'd2, 47'd3, 48'd1, 48'd1, 48'd1, 47'd1, -48'sd1, '0, 48'd1, 1'b0);
		drain_pipeline();
	endtask

	// Unconstrained random parents and children, some with zero mass, at rest or just above rest.
	task automatic test_random(int count);
		logic [E_W-1:0] m1, e1, e2;
		logic [P_W-1:0] px, py, pz, cx, cy, cz;
		int kind;
		for (int i = 0; i < count; i++) begin
			kind = $urandom_range(0, 3);
			m1 = E_W'(rand_field(kind));
			px = rand_field(kind);
			py = rand_field(kind);
			pz = rand_field(kind);
			e2 = E_W'(rand_field(kind));
			cx = rand_field(kind);
			cy = rand_field(kind);
			cz = rand_field(kind);
			e1 = E_W'(rand_field(kind));
			case ($urandom_range(0, 9))
				0: m1 = '0;
				1: e1 = m1;
				2: e1 = m1 + E_W'($urandom_range(0, 3));
				default: ;
			endcase
			send_boost(m1, e1, px, py, pz, e2, cx, cy, cz, 1'b1);
			if (i == count / 2)
				drain_pipeline();
		end
		drain_pipeline();
	endtask

	// Results cannot be held off, so every done cycle is compared right away.
	always @(posedge clk) begin
		boosted_t exp_b;
		if (arst_n && done) begin
			if (expected_boosts.size() == 0) begin
				$display("%0t: unexpected result, no request outstanding", $time);
				errors++;
			end else begin
				exp_b = expected_boosts.pop_front();
				checked++;
				if (invalid)
					invalid_seen++;
				if (lab_energy !== exp_b.energy) begin
					$display("%0t: lab_energy expected %h actual %h", $time, exp_b.energy,
						lab_energy);
					errors++;
				end
				if (lab_mom_x !== exp_b.mx) begin
					$display("%0t: lab_mom_x expected %h actual %h", $time, exp_b.mx,
						lab_mom_x);
					errors++;
				end
				if (lab_mom_y !== exp_b.my) begin
					$display("%0t: lab_mom_y expected %h actual %h", $time, exp_b.my,
						lab_mom_y);
					errors++;
				end
				if (lab_mom_z !== exp_b.mz) begin
					$display("%0t: lab_mom_z expected %h actual %h", $time, exp_b.mz,
						lab_mom_z);
					errors++;
				end
				if (invalid !== exp_b.inv) begin
					$display("%0t: invalid expected %b actual %b", $time, exp_b.inv,
						invalid);
					errors++;
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(540);
		// Let the 116-stage pipeline settle to catch any stray strobe.
		repeat (150) @(posedge clk);
		$display("Checked %0d of %0d requests, %0d with a non-positive parent mass.",
			checked, sent, invalid_seen);
		if (errors == 0 && expected_boosts.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d results outstanding.", expected_boosts.size());
		$display("FAILURE");
		$finish;
	end
endmodule
